// ===== sv/stramp_pkg.sv =====
// Shared types, constants and codes for the trapezoidal ramp step generator.
package stramp_pkg;

   // Field and register widths
   localparam int PER_W      = 16;
   localparam int CNT_W      = 32;
   localparam int CD_W       = PER_W + 1;
   localparam int SHIFT_W    = 3;
   localparam int OP_W       = 3;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Largest microstep shift (thirty-second step)
   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USTEP = 2'd3;

   // Configuration reset values
   localparam logic [PER_W-1:0]   FAST_RST  = 16'd691;
   localparam logic [PER_W-1:0]   SLOW_RST  = 16'd20746;
   localparam logic [PER_W-1:0]   STEP_RST  = 16'd200;
   localparam logic [SHIFT_W-1:0] USTEP_RST = 3'd0;

   // Step budget for a continuous run
   localparam int unsigned RUN_STEPS_DEF = 60000;

   localparam logic [PER_W-1:0] PERIOD_MAX = 16'hFFFF;

   // Command codes
   localparam logic [OP_W-1:0] OP_TICK = 3'd0;
   localparam logic [OP_W-1:0] OP_MOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_RUN  = 3'd2;
   localparam logic [OP_W-1:0] OP_SOFT = 3'd3;
   localparam logic [OP_W-1:0] OP_HARD = 3'd4;

   // Motion phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_SPLIT
   } ctrl_state_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic             dir_cw;
      logic [CNT_W-1:0] move_steps;
   } req_word_type;

   typedef struct packed {
      logic               step_pulse;
      logic               dir_out;
      logic               busy_res;
      logic [PHASE_W-1:0] motion_phase;
      logic [PER_W-1:0]   period_now;
   } rsp_word_type;

   // Periods after the microstep shift
   typedef struct packed {
      logic [PER_W-1:0] wf;
      logic [PER_W-1:0] ws;
      logic [PER_W-1:0] wa;
   } work_cfg_type;

   typedef struct packed {
      logic             start;
      logic [PER_W-1:0] dividend;
      logic [PER_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PER_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/stramp_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle for the ramp length.
module stramp_div
   import stramp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_BITS = $clog2(PER_W);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PER_W - 1);

   logic [PER_W-1:0]     rem_ff, rem_in;
   logic [PER_W-1:0]     quo_ff, quo_in;
   logic [PER_W-1:0]     dsr_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [PER_W:0]       shifted;
   logic [PER_W:0]       trial;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[PER_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = !trial[PER_W];
      rem_in  = fits ? trial[PER_W-1:0] : shifted[PER_W-1:0];
      quo_in  = {quo_ff[PER_W-2:0], fits};
   end

   // Control: step counter, busy and done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // A started divide is in progress on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider did not start");

   // Done is never raised while steps remain
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   // No restart while a divide is running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start)
      else $error("divider restarted while busy");

endmodule

// ===== sv/stramp_ctrl.sv =====
// Command sequencer, motion state and result register of the ramp generator.
module stramp_ctrl
   import stramp_pkg::*;
#(
   parameter int unsigned RUN_STEPS = RUN_STEPS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  work_cfg_type wcfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp
);

   ctrl_state_type state_ff, state_in;

   // Held command word
   logic [OP_W-1:0]  op_ff;
   logic             dir_item_ff;
   logic [CNT_W-1:0] steps_ff;

   // Motion state
   logic [PER_W-1:0] accel_ff, accel_in;
   logic [CNT_W-1:0] cruise_ff, cruise_in;
   logic [PER_W-1:0] decel_ff, decel_in;
   logic [PER_W-1:0] cur_ff, cur_in;
   logic [CD_W-1:0]  cd_ff, cd_in;
   logic             running_ff, running_in;
   logic             cont_ff, cont_in;
   logic             dir_ff, dir_in;

   // Result register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic             is_start;
   logic             slot_free;
   logic             commit;
   logic             pulse;
   logic [PER_W-1:0] ramp_len;
   logic [CNT_W-1:0] count;
   logic [CNT_W:0]   diff;
   logic [PER_W-1:0] half_up;
   logic [CD_W-1:0]  cd_dec;
   logic [CNT_W-1:0] cruise_inc;
   logic [PER_W-1:0] per_sub;
   logic [PER_W-1:0] per_dn;
   logic [PER_W:0]   up_sum;
   logic [PER_W-1:0] per_up;
   logic [PHASE_W-1:0] phase;

   assign is_start  = (op_ff == OP_MOVE) || (op_ff == OP_RUN);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_EXEC;
         S_EXEC: begin
            if (is_start) state_in = S_DIV;
            else if (slot_free) state_in = S_IDLE;
         end
         S_DIV:   if (div_rsp.done) state_in = S_SPLIT;
         S_SPLIT: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall        = (state_ff != S_IDLE);
      div_req.start    = (state_ff == S_EXEC) && is_start;
      div_req.dividend = wcfg.ws - wcfg.wf;
      div_req.divisor  = wcfg.wa;
      commit           = slot_free && ((state_ff == S_SPLIT) ||
                                       ((state_ff == S_EXEC) && !is_start));
   end

   // Arithmetic shared by the command paths
   always_comb begin
      ramp_len = ((wcfg.wa != '0) && (wcfg.ws > wcfg.wf)) ? div_rsp.quotient : '0;
      count    = (op_ff == OP_RUN) ? CNT_W'(RUN_STEPS) : steps_ff;
      diff     = {1'b0, count} - {{(CNT_W - PER_W){1'b0}}, ramp_len, 1'b0};
      half_up  = count[PER_W:1] + PER_W'(count[0]);
      cd_dec   = (cd_ff != '0) ? cd_ff - CD_W'(1) : '0;
      cruise_inc = (cont_ff && (cruise_ff != '1)) ? cruise_ff + CNT_W'(1) : cruise_ff;
      per_sub  = (cur_ff > wcfg.wa) ? cur_ff - wcfg.wa : wcfg.wf;
      per_dn   = (per_sub < wcfg.wf) ? wcfg.wf : per_sub;
      up_sum   = {1'b0, cur_ff} + {1'b0, wcfg.wa};
      per_up   = up_sum[PER_W] ? PERIOD_MAX : up_sum[PER_W-1:0];
   end

   // Motion state update
   always_comb begin
      accel_in   = accel_ff;
      cruise_in  = cruise_ff;
      decel_in   = decel_ff;
      cur_in     = cur_ff;
      cd_in      = cd_ff;
      running_in = running_ff;
      cont_in    = cont_ff;
      dir_in     = dir_ff;
      pulse      = 1'b0;
      if (commit) begin
         if (state_ff == S_SPLIT) begin
            // start of a move or run
            cont_in = (op_ff == OP_RUN);
            dir_in  = dir_item_ff;
            if (!diff[CNT_W] && (diff != '0)) begin
               accel_in  = ramp_len;
               decel_in  = ramp_len;
               cruise_in = diff[CNT_W-1:0];
            end else begin
               cruise_in = '0;
               decel_in  = count[PER_W:1];
               accel_in  = half_up;
            end
            cur_in     = wcfg.ws;
            cd_in      = {1'b0, wcfg.ws} + CD_W'(1);
            running_in = 1'b1;
         end else begin
            unique case (op_ff)
               OP_TICK: begin
                  if (running_ff) begin
                     cd_in = cd_dec;
                     if (cd_dec == '0) begin
                        cruise_in = cruise_inc;
                        priority if (accel_ff != '0) begin
                           cur_in   = per_dn;
                           cd_in    = {1'b0, per_dn};
                           accel_in = accel_ff - PER_W'(1);
                           pulse    = 1'b1;
                        end else if (cruise_inc != '0) begin
                           cruise_in = cruise_inc - CNT_W'(1);
                           cd_in     = {1'b0, wcfg.wf};
                           pulse     = 1'b1;
                        end else if (decel_ff != '0) begin
                           decel_in = decel_ff - PER_W'(1);
                           cur_in   = per_up;
                           cd_in    = {1'b0, per_up};
                           pulse    = 1'b1;
                        end else begin
                           running_in = 1'b0;
                           cd_in      = {1'b0, wcfg.ws} + CD_W'(1);
                        end
                     end
                  end
               end
               OP_SOFT: begin
                  cont_in   = 1'b0;
                  accel_in  = '0;
                  cruise_in = '0;
               end
               OP_HARD: begin
                  cont_in    = 1'b0;
                  accel_in   = '0;
                  cruise_in  = '0;
                  decel_in   = '0;
                  running_in = 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   // Result word from the updated state
   always_comb begin
      priority if (!running_in) phase = PH_IDLE;
      else if (accel_in != '0)  phase = PH_ACCEL;
      else if (cruise_in != '0) phase = PH_CRUISE;
      else                      phase = PH_DECEL;
      rsp_word_in.step_pulse   = pulse;
      rsp_word_in.dir_out      = dir_in;
      rsp_word_in.busy_res     = running_in;
      rsp_word_in.motion_phase = phase;
      rsp_word_in.period_now   = cur_in;
   end

   // Control and motion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         accel_ff     <= '0;
         cruise_ff    <= '0;
         decel_ff     <= '0;
         cur_ff       <= '0;
         cd_ff        <= '0;
         running_ff   <= 1'b0;
         cont_ff      <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         accel_ff   <= accel_in;
         cruise_ff  <= cruise_in;
         decel_ff   <= decel_in;
         cur_ff     <= cur_in;
         cd_ff      <= cd_in;
         running_ff <= running_in;
         cont_ff    <= cont_in;
         dir_ff     <= dir_in;
         if (commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Command word and result payload
   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         op_ff       <= req_word.opcode;
         dir_item_ff <= req_word.dir_cw;
         steps_ff    <= req_word.move_steps;
      end
      if (commit) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Divider finishes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divide finished outside the wait state");

   // A step comes only from a tick while in motion
   a_pulse_src: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_word_in.step_pulse |-> running_ff && op_ff == OP_TICK)
      else $error("step issued without a running tick");

   // An idle result reports the idle phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.busy_res |-> rsp_word_ff.motion_phase == PH_IDLE)
      else $error("idle result with a motion phase");

   // An accepted word is worked on in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

endmodule

// ===== sv/stepper_trapezoid_ramp.sv =====
// Stepper pulse generator with trapezoidal ramp: config registers and top level.
// Tick, stop and status words: the word is executed and its result registered; the next word is
// taken once that result is committed. Move and run words wait first for the 16-step bit-serial
// divide that works out the ramp length (one quotient bit per cycle).
// The result register frees the input side while a finished word waits downstream.
// Reset is synchronous, active high: config registers take their defaults, motion goes idle.
module stepper_trapezoid_ramp
   import stramp_pkg::*;
#(
   parameter int unsigned RUN_STEPS = RUN_STEPS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word
);

   logic [PER_W-1:0]   fast_ff;
   logic [PER_W-1:0]   slow_ff;
   logic [PER_W-1:0]   step_ff;
   logic [SHIFT_W-1:0] ushift_ff;
   logic [SHIFT_W-1:0] shift_amt;
   work_cfg_type       wcfg;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff   <= FAST_RST;
         slow_ff   <= SLOW_RST;
         step_ff   <= STEP_RST;
         ushift_ff <= USTEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAST:  fast_ff   <= csr_wdata[PER_W-1:0];
            CSR_SLOW:  slow_ff   <= csr_wdata[PER_W-1:0];
            CSR_STEP:  step_ff   <= csr_wdata[PER_W-1:0];
            CSR_USTEP: ushift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // Working periods for the microstep mode; modes past 5 act as 5
   always_comb begin
      shift_amt = (ushift_ff > MAX_SHIFT) ? MAX_SHIFT : ushift_ff;
      wcfg.wf   = fast_ff >> shift_amt;
      wcfg.ws   = slow_ff >> shift_amt;
      wcfg.wa   = step_ff >> shift_amt;
   end

   stramp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   stramp_ctrl #(
      .RUN_STEPS (RUN_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .wcfg      (wcfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the trapezoidal ramp step generator.
module testbench
   import stramp_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 30;
   localparam int unsigned HOLD_AT_WORD = 600;
   localparam int unsigned HOLD_CYCLES = 250;
   localparam int unsigned ITEMS_PER_PHASE = 180;
   localparam int unsigned PHASE_COUNT = 9;

   // Opcodes the block ignores apart from reporting status
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;

   // Predictor copy of the registers and the motion state
   logic [PER_W-1:0]   cfg_fast = FAST_RST;
   logic [PER_W-1:0]   cfg_slow = SLOW_RST;
   logic [PER_W-1:0]   cfg_step = STEP_RST;
   logic [SHIFT_W-1:0] cfg_ushift = USTEP_RST;
   logic [PER_W-1:0]   mot_accel = '0;
   logic [CNT_W-1:0]   mot_cruise = '0;
   logic [PER_W-1:0]   mot_decel = '0;
   logic [PER_W-1:0]   mot_period = '0;
   logic [CD_W-1:0]    mot_countdown = '0;
   logic               mot_running = 1'b0;
   logic               mot_continuous = 1'b0;
   logic               mot_dir = 1'b0;

   rsp_word_type pending_status [$];
   plan_row_type directed_plan [$];

   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fault_count = 0;
   int unsigned rsp_seen = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned cycle_count = 0;

   stepper_trapezoid_ramp i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Period after the microstep shift; modes above thirty-second clamp to it
   function automatic logic [PER_W-1:0] scaled(input logic [PER_W-1:0] v);
      return v >> ((cfg_ushift > MAX_SHIFT) ? MAX_SHIFT : cfg_ushift);
   endfunction

   // Advance the motion state by one command word and report the status word
   task automatic step_motor(input req_word_type w, output rsp_word_type r);
      logic [PER_W-1:0] f, s, a;
      logic [CNT_W-1:0] y, count;
      logic [PER_W:0]   sum;
      logic             pulse;
      f = scaled(cfg_fast);
      s = scaled(cfg_slow);
      a = scaled(cfg_step);
      pulse = 1'b0;
      case (w.opcode)
         OP_TICK: begin
            if (mot_running) begin
               if (mot_countdown != 0) mot_countdown = mot_countdown - 1'b1;
               if (mot_countdown == 0) begin
                  // interval expired: issue the next step of the profile
                  if (mot_continuous && mot_cruise != '1) mot_cruise = mot_cruise + 1'b1;
                  if (mot_accel != 0) begin
                     if (mot_period > a) mot_period = mot_period - a;
                     else mot_period = f;
                     if (mot_period < f) mot_period = f;
                     mot_countdown = {1'b0, mot_period};
                     mot_accel = mot_accel - 1'b1;
                     pulse = 1'b1;
                  end else if (mot_cruise != 0) begin
                     mot_cruise = mot_cruise - 1'b1;
                     mot_countdown = {1'b0, f};
                     pulse = 1'b1;
                  end else if (mot_decel != 0) begin
                     mot_decel = mot_decel - 1'b1;
                     sum = {1'b0, mot_period} + {1'b0, a};
                     mot_period = sum[PER_W] ? PERIOD_MAX : sum[PER_W-1:0];
                     mot_countdown = {1'b0, mot_period};
                     pulse = 1'b1;
                  end else begin
                     mot_running = 1'b0;
                     mot_countdown = {1'b0, s} + 1'b1;
                  end
               end
            end
         end
         OP_MOVE, OP_RUN: begin
            // ramp length, then split the count into the three phases
            mot_continuous = (w.opcode == OP_RUN);
            count = (w.opcode == OP_RUN) ? CNT_W'(RUN_STEPS_DEF) : w.move_steps;
            y = '0;
            if (a != 0 && s > f) y = {16'd0, (s - f) / a};
            if ({y, 1'b0} < {1'b0, count}) begin
               mot_accel = y[PER_W-1:0];
               mot_decel = y[PER_W-1:0];
               mot_cruise = count - {y[CNT_W-2:0], 1'b0};
            end else begin
               mot_cruise = '0;
               mot_decel = count[PER_W:1];
               mot_accel = count[PER_W:1] + count[0];
            end
            mot_dir = w.dir_cw;
            mot_period = s;
            mot_countdown = {1'b0, s} + 1'b1;
            mot_running = 1'b1;
         end
         OP_SOFT: begin
            mot_continuous = 1'b0;
            mot_accel = '0;
            mot_cruise = '0;
         end
         OP_HARD: begin
            mot_continuous = 1'b0;
            mot_accel = '0;
            mot_cruise = '0;
            mot_decel = '0;
            mot_running = 1'b0;
         end
         default: ;
      endcase
      r.step_pulse = pulse;
      r.dir_out = mot_dir;
      r.busy_res = mot_running;
      r.motion_phase = !mot_running ? PH_IDLE :
                       (mot_accel != 0) ? PH_ACCEL :
                       (mot_cruise != 0) ? PH_CRUISE : PH_DECEL;
      r.period_now = mot_period;
   endtask

   function automatic rsp_word_type status(input logic pulse, input logic dir,
                                           input logic busy,
                                           input logic [PHASE_W-1:0] phase,
                                           input logic [PER_W-1:0] period);
      rsp_word_type r;
      r.step_pulse = pulse;
      r.dir_out = dir;
      r.busy_res = busy;
      r.motion_phase = phase;
      r.period_now = period;
      return r;
   endfunction

   task automatic plan(input logic [OP_W-1:0] op, input logic dir,
                       input logic [CNT_W-1:0] steps, input bit typed,
                       input rsp_word_type want);
      plan_row_type row;
      row.word.opcode = op;
      row.word.dir_cw = dir;
      row.word.move_steps = steps;
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   // Offer one word, wait for it to be taken, then record what it should produce
   task automatic send_word(input req_word_type w, input bit typed,
                            input rsp_word_type want);
      rsp_word_type r;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      step_motor(w, r);
      pending_status.push_back(typed ? want : r);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_FAST:  cfg_fast = val;
         CSR_SLOW:  cfg_slow = val;
         CSR_STEP:  cfg_step = val;
         CSR_USTEP: cfg_ushift = val[SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [PER_W-1:0] f, input logic [PER_W-1:0] s,
                              input logic [PER_W-1:0] st, input logic [SHIFT_W-1:0] sh);
      write_reg(CSR_FAST, f);
      write_reg(CSR_SLOW, s);
      write_reg(CSR_STEP, st);
      write_reg(CSR_USTEP, CSR_DATA_W'(sh));
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // Random traffic: a command followed by a burst of timer ticks
   task automatic run_random(input int unsigned n);
      req_word_type w;
      int unsigned  sent, burst, pick;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         w.dir_cw = 1'($urandom_range(0, 1));
         w.move_steps = $urandom;
         if (pick < 50) begin
            w.opcode = OP_MOVE;
            if ($urandom_range(0, 7) != 0) w.move_steps = $urandom_range(0, 40);
         end else if (pick < 65) w.opcode = OP_RUN;
         else if (pick < 80) w.opcode = OP_SOFT;
         else if (pick < 92) w.opcode = OP_HARD;
         else w.opcode = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         send_word(w, 1'b0, '0);
         if (w.opcode <= OP_HARD) sent++;
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 25);
         repeat (burst) begin
            if (sent < n) begin
               w.opcode = OP_TICK;
               w.dir_cw = 1'($urandom_range(0, 1));
               w.move_steps = $urandom;
               send_word(w, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // Result checker and receiver stall, with one long hold-off
   always @(posedge clock) begin : status_check
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen = rsp_seen + 1;
            if (pending_status.size() == 0) begin
               $error("status word with nothing expected: %h", rsp_word);
               fault_count++;
            end else begin
               want = pending_status.pop_front();
               if (rsp_word.step_pulse !== want.step_pulse) begin
                  $error("step_pulse: expected %0d, actual %0d",
                         want.step_pulse, rsp_word.step_pulse);
                  fault_count++;
               end
               if (rsp_word.dir_out !== want.dir_out) begin
                  $error("dir_out: expected %0d, actual %0d", want.dir_out, rsp_word.dir_out);
                  fault_count++;
               end
               if (rsp_word.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, actual %0d", want.busy_res, rsp_word.busy_res);
                  fault_count++;
               end
               if (rsp_word.motion_phase !== want.motion_phase) begin
                  $error("motion_phase: expected %0d, actual %0d",
                         want.motion_phase, rsp_word.motion_phase);
                  fault_count++;
               end
               if (rsp_word.period_now !== want.period_now) begin
                  $error("period_now: expected %0d, actual %0d",
                         want.period_now, rsp_word.period_now);
                  fault_count++;
               end
            end
            if (!hold_done && rsp_seen == HOLD_AT_WORD) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
         if (hold_left != 0) hold_left = hold_left - 1;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset configuration: ramp length is 100 steps
      plan(OP_TICK, 1'b0, 32'd0, 1, status(1'b0, 1'b0, 1'b0, PH_IDLE, 16'd0));
      plan(OP_UNUSED_LO, 1'b1, 32'hFFFF_FFFF, 1, status(1'b0, 1'b0, 1'b0, PH_IDLE, 16'd0));
      plan(OP_SOFT, 1'b1, 32'd0, 1, status(1'b0, 1'b0, 1'b0, PH_IDLE, 16'd0));
      plan(OP_HARD, 1'b0, 32'd0, 1, status(1'b0, 1'b0, 1'b0, PH_IDLE, 16'd0));
      // zero-step move: running in the final interval right away
      plan(OP_MOVE, 1'b1, 32'd0, 1, status(1'b0, 1'b1, 1'b1, PH_DECEL, SLOW_RST));
      plan(OP_TICK, 1'b0, 32'd0, 1, status(1'b0, 1'b1, 1'b1, PH_DECEL, SLOW_RST));
      plan(OP_HARD, 1'b0, 32'd0, 1, status(1'b0, 1'b1, 1'b0, PH_IDLE, SLOW_RST));
      plan(OP_MOVE, 1'b0, 32'hFFFF_FFFF, 1, status(1'b0, 1'b0, 1'b1, PH_ACCEL, SLOW_RST));
      plan(OP_UNUSED_HI, 1'b1, 32'd0, 1, status(1'b0, 1'b0, 1'b1, PH_ACCEL, SLOW_RST));
      // soft stop keeps the deceleration
      plan(OP_SOFT, 1'b0, 32'd0, 1, status(1'b0, 1'b0, 1'b1, PH_DECEL, SLOW_RST));
      plan(OP_RUN, 1'b1, 32'd0, 1, status(1'b0, 1'b1, 1'b1, PH_ACCEL, SLOW_RST));
      plan(OP_TICK, 1'b0, 32'hA5A5_5A5A, 0, '0);
      plan(OP_W'(OP_UNUSED_LO + 1'b1), 1'b0, 32'h5A5A_A5A5, 0, '0);
      plan(OP_SOFT, 1'b0, 32'd0, 1, status(1'b0, 1'b1, 1'b1, PH_DECEL, SLOW_RST));
      plan(OP_HARD, 1'b1, 32'd0, 1, status(1'b0, 1'b1, 1'b0, PH_IDLE, SLOW_RST));
      plan(OP_MOVE, 1'b0, 32'd1, 1, status(1'b0, 1'b0, 1'b1, PH_ACCEL, SLOW_RST));
      // moves around twice the ramp length, then a long move
      plan(OP_MOVE, 1'b1, 32'd200, 0, '0);
      plan(OP_MOVE, 1'b1, 32'd201, 0, '0);
      plan(OP_MOVE, 1'b0, 32'h0001_FFFF, 0, '0);
      plan(OP_TICK, 1'b1, 32'd0, 0, '0);
      plan(OP_HARD, 1'b0, 32'd0, 0, '0);
      foreach (directed_plan[i])
         send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);

      // Random phases, each with its own configuration; the idle patterns repeat every four phases
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         drain();
         case (p)
            0: load_config(16'd1, 16'd12, 16'd2, 3'd0);
            1: load_config(16'd1, 16'd2, 16'd65535, 3'd0);
            2: load_config(16'd65535, 16'd1, 16'd1, 3'd0);      // start not slower than top
            3: load_config(16'd65535, 16'd65535, 16'd65535, 3'd7); // mode clamps to 5
            4: load_config(16'd3, 16'd50, 16'd4, 3'd2);         // top period shifts to zero
            5: load_config(16'd40, 16'd8, 16'd3, 3'd3);         // acceleration step of zero
            6: load_config(16'd64, 16'd1000, 16'd32, 3'd5);
            default: load_config(PER_W'($urandom_range(1, 8)), PER_W'($urandom_range(1, 80)),
                                 PER_W'($urandom_range(1, 12)),
                                 SHIFT_W'($urandom_range(0, 7)));
         endcase
         case (p % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
            default: begin send_gap_pct = 15; recv_stall_pct = 15; end
         endcase
         run_random(ITEMS_PER_PHASE);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/stramp_pkg.sv
sv/stramp_div.sv
sv/stramp_ctrl.sv
sv/stepper_trapezoid_ramp.sv
verif/testbench.sv
